/* rtl/cdw_pkg.sv */
// ----------------------------------------------------------------------------
// cdw_pkg: shared types and constants of the concentric disk warp
// Fixed-point widths, request/result structs, stage structs and the
// arctangent table of the rotation chain.
// ----------------------------------------------------------------------------
package cdw_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int ANGLE_STAGES = 16;

  // remapped coordinate, radius and divider remainder widths
  localparam int A_W   = SAMPLE_BITS + 2;
  localparam int R_W   = SAMPLE_BITS + 1;
  localparam int REM_W = SAMPLE_BITS + 2;
  // wedge ratio in Q30, up to and including 1.0
  localparam int Q_W   = 31;
  // rotation datapath and residual angle
  localparam int C_W   = 33;
  localparam int Z_W   = 32;
  // radius scaling shift and product width
  localparam int SH    = SAMPLE_BITS + 15;
  localparam int P_W   = R_W + C_W;
  // square root chain
  localparam int SQ_STAGES = 16;
  localparam int D_W       = 31;

  localparam logic [29:0]          PI4_Q30    = 30'd843314857;
  localparam logic signed [C_W-1:0] GAIN_Q30  = C_W'(652032874);
  localparam logic [29:0]          INV_PI_Q30 = 30'd341782638;
  localparam logic [14:0]          INV_PI_Q16 = 15'd20861;
  localparam logic [30:0]          ONE_Q30    = 31'h4000_0000;
  localparam logic [14:0]          Z_MAX      = 15'h7fff;

  typedef enum logic [1:0] {
    WEDGE_E = 2'd0,
    WEDGE_N = 2'd1,
    WEDGE_W = 2'd2,
    WEDGE_S = 2'd3
  } wedge_t;

  typedef struct packed {
    logic [15:0] sample_u;
    logic [15:0] sample_v;
  } in_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [14:0]        point_z;
    logic [14:0]        density;
  } out_t;

  // per-request geometry carried alongside the angle work
  typedef struct packed {
    logic [R_W-1:0] r;
    logic           neg;
    wedge_t         wedge;
    logic           mode;
  } geo_t;

  typedef struct packed {
    logic             valid;
    geo_t             geo;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } div_t;

  typedef struct packed {
    logic                   valid;
    geo_t                   geo;
    logic signed [Z_W-1:0]  z;
    logic signed [C_W-1:0]  cx;
    logic signed [C_W-1:0]  cy;
  } rot_t;

  typedef struct packed {
    logic               valid;
    logic               mode;
    logic [D_W-1:0]     d;
    logic [D_W-1:0]     res;
  } sqr_t;

  // arctangent of 2^-idx in Q30 radians
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = Z_W'(843314857);
      5'd1:    v = Z_W'(497837829);
      5'd2:    v = Z_W'(263043837);
      5'd3:    v = Z_W'(133525159);
      5'd4:    v = Z_W'(67021687);
      5'd5:    v = Z_W'(33543516);
      5'd6:    v = Z_W'(16775851);
      5'd7:    v = Z_W'(8388437);
      5'd8:    v = Z_W'(4194283);
      5'd9:    v = Z_W'(2097149);
      default: v = Z_W'(ONE_Q30 >> idx);
    endcase
    return v;
  endfunction

endpackage

/* rtl/cdw_div_cell.sv */
// ----------------------------------------------------------------------------
// cdw_div_cell: one quotient bit of the wedge ratio
// Restoring division step; a zero divisor yields zero quotient bits.
// ----------------------------------------------------------------------------
module cdw_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  cdw_pkg::div_t din,
  output cdw_pkg::div_t dout
);
  import cdw_pkg::*;

  logic [REM_W-1:0] dvs;
  logic [REM_W-1:0] kept;
  logic             ge;

  // trial subtract
  always_comb begin
    dvs  = REM_W'(din.geo.r);
    ge   = (din.rem >= dvs) && (din.geo.r != '0);
    kept = ge ? (din.rem - dvs) : din.rem;
  end

  // advance to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.geo <= din.geo;
    dout.rem <= {kept[REM_W-2:0], 1'b0};
    dout.q   <= {din.q[Q_W-2:0], ge};
  end

endmodule

/* rtl/cdw_rot_cell.sv */
// ----------------------------------------------------------------------------
// cdw_rot_cell: one rotation step of the angle-to-cosine/sine chain
// Drives the residual angle toward zero with floor shifts.
// ----------------------------------------------------------------------------
module cdw_rot_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic [4:0]    stage,
  input  cdw_pkg::rot_t din,
  output cdw_pkg::rot_t dout
);
  import cdw_pkg::*;

  logic signed [C_W-1:0] dx;
  logic signed [C_W-1:0] dy;
  logic signed [Z_W-1:0] at;

  always_comb begin
    dx = din.cy >>> stage;
    dy = din.cx >>> stage;
    at = atan_entry(stage);
  end

  // rotate toward the residual angle
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.geo <= din.geo;
    if (din.z >= 0) begin
      dout.cx <= din.cx - dx;
      dout.cy <= din.cy + dy;
      dout.z  <= din.z - at;
    end else begin
      dout.cx <= din.cx + dx;
      dout.cy <= din.cy - dy;
      dout.z  <= din.z + at;
    end
  end

endmodule

/* rtl/cdw_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// cdw_sqrt_cell: one digit of the integer square root
// Tests one result bit per cell, from bit weight 2^30 downward by fours.
// ----------------------------------------------------------------------------
module cdw_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic [3:0]    step,
  input  cdw_pkg::sqr_t din,
  output cdw_pkg::sqr_t dout
);
  import cdw_pkg::*;

  logic [D_W-1:0] bitv;
  logic [D_W-1:0] trial;

  always_comb begin
    bitv  = D_W'(1) << (5'd30 - {step, 1'b0});
    trial = din.res + bitv;
  end

  // accept or reject this result bit
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.mode <= din.mode;
    if (din.d >= trial) begin
      dout.d   <= din.d - trial;
      dout.res <= (din.res >> 1) + bitv;
    end else begin
      dout.d   <= din.d;
      dout.res <= din.res >> 1;
    end
  end

endmodule

/* rtl/concentric_disk_cosine_warp_unit.sv */
// ----------------------------------------------------------------------------
// concentric_disk_cosine_warp_unit: square sample to disk / hemisphere point
// Concentric square-to-disk mapping with optional cosine-weighted lift.
//
//   channel   signals                       direction  handshake
//   request   start, busy, req              in         start && !busy
//   result    done, result                  out        done, one cycle
//   config    cfg_valid, cfg_ready, cfg_data in        cfg_valid && cfg_ready
//
// One request per cycle through these register stages: 1 entry stage, Q_W divider cells,
// 1 angle multiply, ANGLE_STAGES rotation cells, 1 scale, 1 square,
// SQ_STAGES root cells and 1 output stage (68 register stages at default
// sizes). The divider chain sets the depth. busy stays low; reset clears
// the valid bits of every stage and the mode register. Results leave as
// a one-cycle strobe and are never held off.
// ----------------------------------------------------------------------------
module concentric_disk_cosine_warp_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cdw_pkg::in_t  req,
  output logic          done,
  output cdw_pkg::out_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);
  import cdw_pkg::*;

  logic warp_mode;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      warp_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      warp_mode <= cfg_data;
    end
  end

  // remap to [-1,1) and pick the wedge
  logic [SAMPLE_BITS-1:0]   su;
  logic [SAMPLE_BITS-1:0]   sv;
  logic signed [A_W-1:0]    a;
  logic signed [A_W-1:0]    b;
  logic signed [A_W-1:0]    na;
  logic signed [A_W-1:0]    nb;
  logic [A_W-1:0]           abs_a;
  logic [A_W-1:0]           abs_b;
  div_t                     entry;

  always_comb begin
    su    = SAMPLE_BITS'(req.sample_u);
    sv    = SAMPLE_BITS'(req.sample_v);
    a     = $signed({1'b0, su, 1'b0}) - $signed(A_W'(1) << SAMPLE_BITS);
    b     = $signed({1'b0, sv, 1'b0}) - $signed(A_W'(1) << SAMPLE_BITS);
    na    = -a;
    nb    = -b;
    abs_a = (a < 0) ? na : a;
    abs_b = (b < 0) ? nb : b;
    entry.valid    = start && !busy;
    entry.geo.mode = warp_mode;
    entry.q        = '0;
    priority if (a > nb && a > b) begin
      entry.geo.wedge = WEDGE_E;
      entry.geo.r     = R_W'(a);
      entry.rem       = REM_W'(abs_b);
      entry.geo.neg   = (b < 0);
    end else if (a > nb) begin
      entry.geo.wedge = WEDGE_N;
      entry.geo.r     = R_W'(b);
      entry.rem       = REM_W'(abs_a);
      entry.geo.neg   = (a > 0);
    end else if (a < b) begin
      entry.geo.wedge = WEDGE_W;
      entry.geo.r     = R_W'(na);
      entry.rem       = REM_W'(abs_b);
      entry.geo.neg   = (b > 0);
    end else begin
      entry.geo.wedge = WEDGE_S;
      entry.geo.r     = R_W'(nb);
      entry.rem       = REM_W'(abs_a);
      entry.geo.neg   = (a < 0);
    end
  end

  div_t dv [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else begin
      dv[0].valid <= entry.valid;
    end
    dv[0].geo <= entry.geo;
    dv[0].rem <= entry.rem;
    dv[0].q   <= entry.q;
  end

  // divider chain: ratio in Q30
  for (genvar i = 0; i < Q_W; i++) begin : g_div
    cdw_div_cell u_div (.clk(clk), .rst(rst), .din(dv[i]), .dout(dv[i+1]));
  end

  // scale the ratio by pi/4 to get the angle
  logic [Q_W+30:0] theta_p;
  rot_t            rv [0:ANGLE_STAGES];

  assign theta_p = (Q_W+31)'(dv[Q_W].q) * (Q_W+31)'(PI4_Q30) + ((Q_W+31)'(1) << 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0].valid <= 1'b0;
    end else begin
      rv[0].valid <= dv[Q_W].valid;
    end
    rv[0].geo <= dv[Q_W].geo;
    rv[0].z   <= $signed(theta_p[30 +: Z_W]);
    rv[0].cx  <= GAIN_Q30;
    rv[0].cy  <= '0;
  end

  // rotation chain
  for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_rot
    cdw_rot_cell u_rot (
      .clk(clk), .rst(rst), .stage(5'(i)), .din(rv[i]), .dout(rv[i+1])
    );
  end

  // scale by the radius, place in the wedge, saturate
  rot_t                  rl;
  logic signed [C_W-1:0] cyn;
  logic [C_W-1:0]        mag_c;
  logic [C_W-1:0]        mag_s;
  logic [P_W-1:0]        pc;
  logic [P_W-1:0]        ps;
  logic signed [18:0]    cr;
  logic signed [18:0]    sr;
  logic signed [18:0]    xw;
  logic signed [18:0]    yw;
  logic signed [15:0]    xs;
  logic signed [15:0]    ys;

  always_comb begin
    rl    = rv[ANGLE_STAGES];
    cyn   = rl.geo.neg ? -rl.cy : rl.cy;
    mag_c = (rl.cx < 0) ? C_W'(-rl.cx) : C_W'(rl.cx);
    mag_s = (cyn < 0) ? C_W'(-cyn) : C_W'(cyn);
    pc    = (P_W'(rl.geo.r) * P_W'(mag_c) + (P_W'(1) << (SH - 1))) >> SH;
    ps    = (P_W'(rl.geo.r) * P_W'(mag_s) + (P_W'(1) << (SH - 1))) >> SH;
    cr    = (rl.cx < 0) ? -$signed({1'b0, pc[17:0]}) : $signed({1'b0, pc[17:0]});
    sr    = (cyn < 0) ? -$signed({1'b0, ps[17:0]}) : $signed({1'b0, ps[17:0]});
    unique case (rl.geo.wedge)
      WEDGE_E: begin xw = cr;  yw = sr;  end
      WEDGE_N: begin xw = -sr; yw = cr;  end
      WEDGE_W: begin xw = -cr; yw = -sr; end
      default: begin xw = sr;  yw = -cr; end
    endcase
    if (xw > 19'sd32767) begin
      xs = 16'sh7fff;
    end else if (xw < -19'sd32768) begin
      xs = -16'sh8000;
    end else begin
      xs = xw[15:0];
    end
    if (yw > 19'sd32767) begin
      ys = 16'sh7fff;
    end else if (yw < -19'sd32768) begin
      ys = -16'sh8000;
    end else begin
      ys = yw[15:0];
    end
  end

  logic               xy_valid;
  logic               xy_mode;
  logic signed [15:0] xy_x;
  logic signed [15:0] xy_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_valid <= 1'b0;
    end else begin
      xy_valid <= rl.valid;
    end
    xy_mode <= rl.geo.mode;
    xy_x    <= xs;
    xy_y    <= ys;
  end

  // form 1 - x^2 - y^2, clamped at zero
  logic signed [33:0] dd;
  sqr_t               qv [0:SQ_STAGES];
  logic signed [15:0] px_x [0:SQ_STAGES];
  logic signed [15:0] px_y [0:SQ_STAGES];

  assign dd = $signed({3'b0, ONE_Q30}) - 34'(xy_x) * 34'(xy_x) - 34'(xy_y) * 34'(xy_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0].valid <= 1'b0;
    end else begin
      qv[0].valid <= xy_valid;
    end
    qv[0].mode <= xy_mode;
    qv[0].d    <= (dd > 0) ? D_W'(dd) : '0;
    qv[0].res  <= '0;
    px_x[0]    <= xy_x;
    px_y[0]    <= xy_y;
  end

  // root chain, with the point riding alongside
  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
    cdw_sqrt_cell u_sqrt (
      .clk(clk), .rst(rst), .step(4'(i)), .din(qv[i]), .dout(qv[i+1])
    );
    always_ff @(posedge clk) begin
      px_x[i+1] <= px_x[i];
      px_y[i+1] <= px_y[i];
    end
  end

  // cap height, form density, drive the result
  logic [14:0] pz;
  logic [47:0] dens_p;
  sqr_t        ql;

  always_comb begin
    ql     = qv[SQ_STAGES];
    pz     = (ql.res >= D_W'(Z_MAX)) ? Z_MAX : ql.res[14:0];
    dens_p = 48'(pz) * 48'({INV_PI_Q30, 1'b0}) + (48'(1) << 29);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ql.valid;
    end
    result.point_x <= px_x[SQ_STAGES];
    result.point_y <= px_y[SQ_STAGES];
    if (ql.mode) begin
      result.point_z <= pz;
      result.density <= dens_p[44:30];
    end else begin
      result.point_z <= '0;
      result.density <= INV_PI_Q16;
    end
  end

endmodule

/* dv/tb_concentric_disk_cosine_warp_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_concentric_disk_cosine_warp_unit: self-checking bench of the disk warp
// Drives square samples from a pending queue, predicts each disk or
// hemisphere point in fixed point, and checks every strobed result in order
// across both warp modes and several idling profiles.
// ----------------------------------------------------------------------------
module tb_concentric_disk_cosine_warp_unit;
  import cdw_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 2000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  req;
  logic done;
  out_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  in_t  pending_q[$];
  out_t point_q[$];
  logic cur_mode;
  int   gap_pct;
  int   idle_cycles;
  bit   failed;

  concentric_disk_cosine_warp_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint fshift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint radius_scale(longint r, longint c);
    longint m, p;
    m = (c < 0) ? -c : c;
    p = (r * m + (64'sd1 <<< 30)) >>> 31;
    return (c < 0) ? -p : p;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint root30(longint d);
    longint res, bt;
    res = 0;
    bt = 64'sd1 <<< 30;
    while (bt > d) bt = bt >>> 2;
    while (bt != 0) begin
      if (d >= res + bt) begin
        d = d - (res + bt);
        res = (res >>> 1) + bt;
      end else begin
        res = res >>> 1;
      end
      bt = bt >>> 2;
    end
    return res;
  endfunction

  // compute the disk / hemisphere point of one square sample
  function automatic out_t warp_point(in_t s, logic mode);
    longint a, b, r, num, tq, th, z, cx, cy, dx, dy, cr, sr, x, y, d, pz, dens, at;
    bit neg;
    wedge_t w;
    out_t o;
    a = 2 * longint'(s.sample_u) - 65536;
    b = 2 * longint'(s.sample_v) - 65536;
    if (a > -b) begin
      if (a > b) begin
        w = WEDGE_E; r = a; num = (b < 0) ? -b : b; neg = b < 0;
      end else begin
        w = WEDGE_N; r = b; num = (a < 0) ? -a : a; neg = a > 0;
      end
    end else begin
      if (a < b) begin
        w = WEDGE_W; r = -a; num = (b < 0) ? -b : b; neg = b > 0;
      end else begin
        w = WEDGE_S; r = -b; num = (a < 0) ? -a : a; neg = a < 0;
      end
    end
    tq = (r != 0) ? (num <<< 30) / r : 0;
    th = (tq * 843314857 + (64'sd1 <<< 29)) >>> 30;
    z = th;
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < ANGLE_STAGES; i++) begin
      dx = fshift(cy, i);
      dy = fshift(cx, i);
      at = atan_entry(5'(i));
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= at;
      end else begin
        cx += dx; cy -= dy; z += at;
      end
    end
    if (neg) cy = -cy;
    cr = radius_scale(r, cx);
    sr = radius_scale(r, cy);
    case (w)
      WEDGE_E: begin x = cr;  y = sr;  end
      WEDGE_N: begin x = -sr; y = cr;  end
      WEDGE_W: begin x = -cr; y = -sr; end
      default: begin x = sr;  y = -cr; end
    endcase
    x = clip16(x);
    y = clip16(y);
    pz = 0;
    dens = 20861;
    if (mode) begin
      d = (64'sd1 <<< 30) - x * x - y * y;
      if (d > 0) begin
        pz = root30(d);
        if (pz > 32767) pz = 32767;
      end
      dens = (pz * 2 * 341782638 + (64'sd1 <<< 29)) >>> 30;
    end
    o.point_x = 16'(x);
    o.point_y = 16'(y);
    o.point_z = 15'(pz);
    o.density = 15'(dens);
    return o;
  endfunction

  // feed requests, idling at random, and predict each accepted one
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        point_q.push_back(warp_point(req, cur_mode));
        void'(pending_q.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
        start <= 1'b1;
        req   <= pending_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // check each strobed result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (point_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        failed = 1'b1;
      end else begin
        out_t e;
        e = point_q.pop_front();
        if (e.point_x !== result.point_x)
          $display("%0t: point_x expected %0d actual %0d", $time, e.point_x, result.point_x);
        if (e.point_y !== result.point_y)
          $display("%0t: point_y expected %0d actual %0d", $time, e.point_y, result.point_y);
        if (e.point_z !== result.point_z)
          $display("%0t: point_z expected %0d actual %0d", $time, e.point_z, result.point_z);
        if (e.density !== result.density)
          $display("%0t: density expected %0d actual %0d", $time, e.density, result.density);
        if (e !== result) failed = 1'b1;
      end
    end
  end

  // count cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = m;
    cfg_valid <= 1'b0;
  endtask

  // hold until every request is in and every result has arrived
  task automatic drain();
    while (pending_q.size() > 0 || start || point_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_random(int n);
    in_t s;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          s.sample_u = 16'($urandom_range(32767 - 64, 32768 + 64));
          s.sample_v = 16'($urandom);
        end
        1: begin
          s.sample_u = 16'($urandom);
          s.sample_v = ($urandom_range(1)) ? 16'($urandom_range(15)) :
                                             16'(65535 - $urandom_range(15));
        end
        default: begin
          s.sample_u = 16'($urandom);
          s.sample_v = 16'($urandom);
        end
      endcase
      pending_q.push_back(s);
    end
  endtask

  initial begin
    in_t s;
    int corner[6] = '{0, 1, 32767, 32768, 32769, 65535};
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    cur_mode = 1'b0;
    gap_pct = 26;
    idle_cycles = 0;
    failed = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed corners in disk mode: centre, edges, full radius, diagonals
    foreach (corner[i]) begin
      s.sample_u = 16'(corner[i]);
      s.sample_v = 16'(corner[(i * 2 + 1) % 6]);
      pending_q.push_back(s);
    end
    s.sample_u = 16'd32768; s.sample_v = 16'd32768; pending_q.push_back(s);
    s.sample_u = 16'd65535; s.sample_v = 16'd32768; pending_q.push_back(s);
    s.sample_u = 16'd0;     s.sample_v = 16'd0;     pending_q.push_back(s);
    s.sample_u = 16'd65535; s.sample_v = 16'd65535; pending_q.push_back(s);
    s.sample_u = 16'hAAAA;  s.sample_v = 16'h5555;  pending_q.push_back(s);
    drain();

    // hemisphere mode, including full radius where the lift underflows
    write_mode(1'b1);
    foreach (corner[i]) begin
      s.sample_u = 16'(corner[i]);
      s.sample_v = 16'(corner[5 - i]);
      pending_q.push_back(s);
    end
    s.sample_u = 16'd32768; s.sample_v = 16'd32768; pending_q.push_back(s);
    s.sample_u = 16'd32768; s.sample_v = 16'd0;     pending_q.push_back(s);
    add_random(280);
    drain();

    gap_pct = 69;
    write_mode(1'b0);
    add_random(280);
    drain();

    gap_pct = 0;
    write_mode(1'b1);
    add_random(280);
    drain();

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
